// File: src/ptld_pkg.sv
`default_nettype none
package ptld_pkg;

  // widths of the datapath
  localparam int unsigned COORD_W = 24;
  localparam int unsigned DIFF_W  = 25;
  localparam int unsigned PROD_W  = 49;
  localparam int unsigned MAG_W   = 49;
  localparam int unsigned DSQ_W   = 48;
  localparam int unsigned NUM_W   = 98;
  localparam int unsigned RAD_W   = 64;
  localparam int unsigned ROOT_W  = 32;
  localparam int unsigned SREM_W  = 34;
  localparam int unsigned DIST_W  = 32;

  // one long-division step per cell, one root bit per cell
  localparam int unsigned NUM_DIV_CELLS  = NUM_W;
  localparam int unsigned NUM_SQRT_CELLS = ROOT_W;

  typedef struct packed {
    logic [DSQ_W-1:0] rem;
    logic [NUM_W-1:0] nq;
    logic [DSQ_W-1:0] den;
    logic             zero;
  } div_stage_t;

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
    logic              zero;
  } sqrt_stage_t;

endpackage
`default_nettype wire

// File: src/ptld_front.sv
`default_nettype none
module ptld_front
  import ptld_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_v,
  input  wire logic signed [COORD_W-1:0] origin_x,
  input  wire logic signed [COORD_W-1:0] origin_y,
  input  wire logic signed [COORD_W-1:0] origin_z,
  input  wire logic signed [COORD_W-1:0] dir_x,
  input  wire logic signed [COORD_W-1:0] dir_y,
  input  wire logic signed [COORD_W-1:0] dir_z,
  input  wire logic signed [COORD_W-1:0] query_x,
  input  wire logic signed [COORD_W-1:0] query_y,
  input  wire logic signed [COORD_W-1:0] query_z,
  output logic                           out_v,
  output div_stage_t                     out_d
);

  logic [5:0] v;

  // stage 1: offset from origin
  logic signed [DIFF_W-1:0]  ux, uy, uz;
  logic signed [COORD_W-1:0] dx, dy, dz;
  // stage 2: products
  logic signed [PROD_W-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  logic [DSQ_W-2:0] sx, sy, sz;
  // stage 3: cross magnitudes and direction square
  logic [MAG_W-1:0] mx, my, mz;
  logic [DSQ_W-1:0] dsq3, dsq4, dsq5;
  // stage 4: partial squares
  logic [47:0] hh [3];
  logic [48:0] hl [3];
  logic [49:0] ll [3];
  // stage 5: component squares
  logic [NUM_W-1:0] csq [3];

  logic signed [PROD_W:0] cx_c, cy_c, cz_c;
  logic [MAG_W-1:0] m [3];

  always_comb begin
    cx_c = {p_yz[PROD_W-1], p_yz} - {p_zy[PROD_W-1], p_zy};
    cy_c = {p_zx[PROD_W-1], p_zx} - {p_xz[PROD_W-1], p_xz};
    cz_c = {p_xy[PROD_W-1], p_xy} - {p_yx[PROD_W-1], p_yx};
  end

  assign m[0] = mx;
  assign m[1] = my;
  assign m[2] = mz;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux <= DIFF_W'(query_x) - DIFF_W'(origin_x);
      uy <= DIFF_W'(query_y) - DIFF_W'(origin_y);
      uz <= DIFF_W'(query_z) - DIFF_W'(origin_z);
      dx <= dir_x;
      dy <= dir_y;
      dz <= dir_z;

      p_yz <= PROD_W'(uy * dz);
      p_zy <= PROD_W'(uz * dy);
      p_zx <= PROD_W'(uz * dx);
      p_xz <= PROD_W'(ux * dz);
      p_xy <= PROD_W'(ux * dy);
      p_yx <= PROD_W'(uy * dx);
      sx   <= (DSQ_W-1)'(dx * dx);
      sy   <= (DSQ_W-1)'(dy * dy);
      sz   <= (DSQ_W-1)'(dz * dz);

      mx   <= cx_c[PROD_W] ? MAG_W'(-cx_c) : MAG_W'(cx_c);
      my   <= cy_c[PROD_W] ? MAG_W'(-cy_c) : MAG_W'(cy_c);
      mz   <= cz_c[PROD_W] ? MAG_W'(-cz_c) : MAG_W'(cz_c);
      dsq3 <= DSQ_W'(sx) + DSQ_W'(sy) + DSQ_W'(sz);

      for (int i = 0; i < 3; i++) begin
        hh[i] <= m[i][48:25] * m[i][48:25];
        hl[i] <= m[i][48:25] * m[i][24:0];
        ll[i] <= m[i][24:0] * m[i][24:0];
        csq[i] <= (NUM_W'(hh[i]) << 50) + (NUM_W'(hl[i]) << 26) + NUM_W'(ll[i]);
      end
      dsq4 <= dsq3;
      dsq5 <= dsq4;

      out_d.rem  <= '0;
      out_d.nq   <= csq[0] + csq[1] + csq[2];
      out_d.den  <= dsq5;
      out_d.zero <= (dsq5 == '0);
    end
  end

  assign out_v = v[5];

endmodule
`default_nettype wire

// File: src/ptld_div_cell.sv
`default_nettype none
module ptld_div_cell
  import ptld_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic       in_v,
  input  div_stage_t      in_d,
  output logic            out_v,
  output div_stage_t      out_d
);

  logic [DSQ_W:0] t;
  logic           ge;

  // one restoring step: bring down the next numerator bit
  always_comb begin
    t  = {in_d.rem, in_d.nq[NUM_W-1]};
    ge = (t >= {1'b0, in_d.den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d.rem  <= ge ? DSQ_W'(t - {1'b0, in_d.den}) : DSQ_W'(t);
      out_d.nq   <= {in_d.nq[NUM_W-2:0], ge};
      out_d.den  <= in_d.den;
      out_d.zero <= in_d.zero;
    end
  end

endmodule
`default_nettype wire

// File: src/ptld_sqrt_cell.sv
`default_nettype none
module ptld_sqrt_cell
  import ptld_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic       in_v,
  input  sqrt_stage_t     in_d,
  output logic            out_v,
  output sqrt_stage_t     out_d
);

  logic [SREM_W+1:0] t;
  logic [SREM_W+1:0] trial;
  logic              ge;

  // one root bit: take two radicand bits, try root*4+1
  always_comb begin
    t     = {in_d.rem, in_d.rad[RAD_W-1:RAD_W-2]};
    trial = (SREM_W+2)'({in_d.root, 2'b01});
    ge    = (t >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d.rem  <= ge ? SREM_W'(t - trial) : SREM_W'(t);
      out_d.rad  <= {in_d.rad[RAD_W-3:0], 2'b00};
      out_d.root <= {in_d.root[ROOT_W-2:0], ge};
      out_d.zero <= in_d.zero;
    end
  end

endmodule
`default_nettype wire

// File: src/point_to_line_distance_3d.sv
// channel | signals                                   | beat
// in      | in_valid, in_ready, origin_*, dir_*, query_* | ray and query point
// out     | out_valid, out_ready, line_distance, zero_direction | distance
//
// one beat per cycle while the output is not stalled; the pipeline is the front stages,
// then one divide cell per quotient bit and one root cell per root bit
// rst clears every stage valid; payload registers are not reset
// a stalled output freezes the whole chain; in_ready = !out_valid | out_ready
`default_nettype none
module point_to_line_distance_3d
  import ptld_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [COORD_W-1:0] origin_x,
  input  wire logic signed [COORD_W-1:0] origin_y,
  input  wire logic signed [COORD_W-1:0] origin_z,
  input  wire logic signed [COORD_W-1:0] dir_x,
  input  wire logic signed [COORD_W-1:0] dir_y,
  input  wire logic signed [COORD_W-1:0] dir_z,
  input  wire logic signed [COORD_W-1:0] query_x,
  input  wire logic signed [COORD_W-1:0] query_y,
  input  wire logic signed [COORD_W-1:0] query_z,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [DIST_W-1:0]              line_distance,
  output logic                           zero_direction
);

  logic        en;
  logic        dv [NUM_DIV_CELLS+1];
  div_stage_t  dd [NUM_DIV_CELLS+1];
  logic        sv [NUM_SQRT_CELLS+1];
  sqrt_stage_t sd [NUM_SQRT_CELLS+1];
  logic [NUM_W-1:0] quot;

  // global advance: last stage empty or being taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  ptld_front u_front (
    .clk, .rst, .en,
    .in_v     (in_valid && in_ready),
    .origin_x, .origin_y, .origin_z,
    .dir_x, .dir_y, .dir_z,
    .query_x, .query_y, .query_z,
    .out_v    (dv[0]),
    .out_d    (dd[0])
  );

  // long division chain
  for (genvar i = 0; i < NUM_DIV_CELLS; i++) begin : g_div
    ptld_div_cell u_cell (
      .clk, .rst, .en,
      .in_v  (dv[i]),
      .in_d  (dd[i]),
      .out_v (dv[i+1]),
      .out_d (dd[i+1])
    );
  end

  // saturate quotient to 64 bits
  assign quot       = dd[NUM_DIV_CELLS].nq;
  assign sv[0]      = dv[NUM_DIV_CELLS];
  assign sd[0].rem  = '0;
  assign sd[0].rad  = (quot[NUM_W-1:RAD_W] != '0) ? '1 : quot[RAD_W-1:0];
  assign sd[0].root = '0;
  assign sd[0].zero = dd[NUM_DIV_CELLS].zero;

  // square root chain
  for (genvar i = 0; i < NUM_SQRT_CELLS; i++) begin : g_sqrt
    ptld_sqrt_cell u_cell (
      .clk, .rst, .en,
      .in_v  (sv[i]),
      .in_d  (sd[i]),
      .out_v (sv[i+1]),
      .out_d (sd[i+1])
    );
  end

  assign out_valid      = sv[NUM_SQRT_CELLS];
  assign zero_direction = sd[NUM_SQRT_CELLS].zero;
  assign line_distance  = sd[NUM_SQRT_CELLS].zero ? '0 : sd[NUM_SQRT_CELLS].root;

`ifndef SYNTHESIS
  a_zero_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_direction |-> line_distance == '0)
    else $error("zero direction with nonzero distance");
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !dv[NUM_DIV_CELLS])
    else $error("pipeline not empty after reset");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dv[NUM_DIV_CELLS]) && $stable(sv[0]))
    else $error("chain moved during stall");
`endif

endmodule
`default_nettype wire
